### rtl/scaled_euler_rotation_matrix_unit_assert.svh
// Assertion macros for the scaled Euler rotation matrix unit.
// Used by the top level only; no other dependencies.
`ifndef SCALED_EULER_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define SCALED_EULER_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SERU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SERU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/seru_pkg.sv
// Shared constants and elaboration-time functions for the scaled Euler rotation unit.
// Holds the quarter-wave trig table generator; no dependencies.
package seru_pkg;

    localparam int ANGLE_STEPS        = 360;
    localparam int QUARTER            = ANGLE_STEPS / 4;
    localparam int ANGLE_W            = 9;
    localparam int QIDX_W             = $clog2(QUARTER);
    localparam int SCALE_W            = 16;
    localparam int RES_W              = 16;
    localparam int NUM_AXES           = 3;
    localparam int NUM_ENTRIES        = 9;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    // Axis slots in the angle, scale and trig arrays
    localparam int AX = 0;
    localparam int AY = 1;
    localparam int AZ = 2;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Series generator constants (Q30 working precision)
    localparam int          WORK_BITS    = 30;
    localparam int          SERIES_TERMS = 12;
    localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;
    localparam logic [63:0] SIN_DIV [SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam logic [63:0] COS_DIV [SERIES_TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    // Q30 sine or cosine of r whole degrees, r below a quarter turn.
    // Evaluated only at elaboration to build the constant table.
    function automatic logic [63:0] series_q30(input int unsigned r, input logic want_cos);
        logic [63:0]        k62;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        ts;
        logic [63:0]        tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        k62 = PI_Q62 / 64'(ANGLE_STEPS / 2);
        x   = (64'(r) * k62 + (64'd1 << 31)) >> 32;
        x2  = (x * x) >> WORK_BITS;
        ts  = x;
        tc  = 64'd1 << WORK_BITS;
        ss  = $signed(x);
        cs  = $signed(tc);
        for (int k = 0; k < SERIES_TERMS; k++) begin
            ts = ((ts * x2) >> WORK_BITS) / SIN_DIV[k];
            tc = ((tc * x2) >> WORK_BITS) / COS_DIV[k];
            // odd terms subtract
            if ((k % 2) == 0) begin
                ss = ss - $signed(ts);
                cs = cs - $signed(tc);
            end else begin
                ss = ss + $signed(ts);
                cs = cs + $signed(tc);
            end
        end
        return want_cos ? cs : ss;
    endfunction

    // Round a non-negative value right by sh bits, half up
    function automatic logic [63:0] round_work(input logic [63:0] v, input int unsigned sh);
        if (sh == 0) begin
            return v;
        end
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

endpackage

### rtl/seru_angle.sv
// Angle reduction and quarter-wave trig table lookup (two pipeline stages).
// Depends on seru_pkg for table generation and quadrant codes.
module seru_angle #(
    parameter int TRIG_FRAC_BITS = seru_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  logic [seru_pkg::NUM_AXES-1:0][seru_pkg::ANGLE_W-1:0]  i_angle,
    input  logic [seru_pkg::NUM_AXES-1:0][seru_pkg::SCALE_W-1:0]  i_scale,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output logic [seru_pkg::NUM_AXES-1:0][TRIG_FRAC_BITS+1:0]     o_sin,
    output logic [seru_pkg::NUM_AXES-1:0][TRIG_FRAC_BITS+1:0]     o_cos,
    output logic [seru_pkg::NUM_AXES-1:0][seru_pkg::SCALE_W-1:0]  o_scale
);
    import seru_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int UW = TRIG_FRAC_BITS + 1;

    // Quarter-wave constant tables, unsigned, built at elaboration
    logic [UW-1:0] w_sin_tab [QUARTER];
    logic [UW-1:0] w_cos_tab [QUARTER];

    for (genvar g = 0; g < QUARTER; g++) begin : g_tab
        assign w_sin_tab[g] = UW'(round_work(series_q30(g, 1'b0), WORK_BITS - TRIG_FRAC_BITS));
        assign w_cos_tab[g] = UW'(round_work(series_q30(g, 1'b1), WORK_BITS - TRIG_FRAC_BITS));
    end

    logic                               w_en1;
    logic                               w_en2;
    logic                               r_v1;
    logic                               r_v2;
    logic [NUM_AXES-1:0][1:0]           r_quad1;
    logic [NUM_AXES-1:0][1:0]           n_quad1;
    logic [NUM_AXES-1:0][QIDX_W-1:0]    r_idx1;
    logic [NUM_AXES-1:0][QIDX_W-1:0]    n_idx1;
    logic [NUM_AXES-1:0][SCALE_W-1:0]   r_scale1;
    logic [NUM_AXES-1:0][SCALE_W-1:0]   r_scale2;
    logic [NUM_AXES-1:0][TW-1:0]        r_sin2;
    logic [NUM_AXES-1:0][TW-1:0]        r_cos2;
    logic [NUM_AXES-1:0][TW-1:0]        n_sin2;
    logic [NUM_AXES-1:0][TW-1:0]        n_cos2;

    // Stage enables: a stage loads when empty or when its contents move on
    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // Stage 1: wrap to 0..359, split into quadrant and offset
    always_comb begin
        logic [ANGLE_W-1:0] v_ang;
        v_ang = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            v_ang = i_angle[i];
            if (v_ang >= ANGLE_W'(ANGLE_STEPS)) begin
                v_ang = v_ang - ANGLE_W'(ANGLE_STEPS);
            end
            priority if (v_ang >= ANGLE_W'(3 * QUARTER)) begin
                n_quad1[i] = QUAD_3;
                n_idx1[i]  = QIDX_W'(v_ang - ANGLE_W'(3 * QUARTER));
            end else if (v_ang >= ANGLE_W'(2 * QUARTER)) begin
                n_quad1[i] = QUAD_2;
                n_idx1[i]  = QIDX_W'(v_ang - ANGLE_W'(2 * QUARTER));
            end else if (v_ang >= ANGLE_W'(QUARTER)) begin
                n_quad1[i] = QUAD_1;
                n_idx1[i]  = QIDX_W'(v_ang - ANGLE_W'(QUARTER));
            end else begin
                n_quad1[i] = QUAD_0;
                n_idx1[i]  = QIDX_W'(v_ang);
            end
        end
    end

    // Stage 2: table read and quadrant symmetry
    always_comb begin
        logic [TW-1:0] v_s0;
        logic [TW-1:0] v_c0;
        v_s0 = '0;
        v_c0 = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            v_s0 = TW'(w_sin_tab[r_idx1[i]]);
            v_c0 = TW'(w_cos_tab[r_idx1[i]]);
            unique case (r_quad1[i])
                QUAD_0: begin
                    n_sin2[i] = v_s0;
                    n_cos2[i] = v_c0;
                end
                QUAD_1: begin
                    n_sin2[i] = v_c0;
                    n_cos2[i] = -v_s0;
                end
                QUAD_2: begin
                    n_sin2[i] = -v_s0;
                    n_cos2[i] = -v_c0;
                end
                default: begin
                    n_sin2[i] = -v_c0;
                    n_cos2[i] = v_s0;
                end
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_quad1  <= n_quad1;
            r_idx1   <= n_idx1;
            r_scale1 <= i_scale;
        end
        if (w_en2 && r_v1) begin
            r_sin2   <= n_sin2;
            r_cos2   <= n_cos2;
            r_scale2 <= r_scale1;
        end
    end

    assign o_valid = r_v2;
    assign o_sin   = r_sin2;
    assign o_cos   = r_cos2;
    assign o_scale = r_scale2;

endmodule

### rtl/seru_coef.sv
// Rotation coefficients from sines and cosines (two multiply stages).
// Depends on seru_pkg for axis slots and counts.
module seru_coef #(
    parameter int TRIG_FRAC_BITS = seru_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  logic [seru_pkg::NUM_AXES-1:0][TRIG_FRAC_BITS+1:0]     i_sin,
    input  logic [seru_pkg::NUM_AXES-1:0][TRIG_FRAC_BITS+1:0]     i_cos,
    input  logic [seru_pkg::NUM_AXES-1:0][seru_pkg::SCALE_W-1:0]  i_scale,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output logic [seru_pkg::NUM_ENTRIES-1:0][TRIG_FRAC_BITS+2:0]  o_coef,
    output logic [seru_pkg::NUM_AXES-1:0][seru_pkg::SCALE_W-1:0]  o_scale
);
    import seru_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int CW = TRIG_FRAC_BITS + 3;
    localparam int PW = 2 * TW;

    // Trig product rounded back to TRIG_FRAC_BITS, half away from zero
    function automatic logic signed [TW-1:0] tmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [PW-1:0] p;
        logic [PW-1:0]        mag;
        logic [PW:0]          rnd;
        logic [TW-1:0]        res;
        p   = a * b;
        mag = p[PW-1] ? -p : p;
        rnd = ({1'b0, mag} + ((PW + 1)'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        res = rnd[TW-1:0];
        return p[PW-1] ? -res : res;
    endfunction

    logic w_en3;
    logic w_en4;
    logic r_v3;
    logic r_v4;

    // Stage 3 registers: products of two table values, plus sx, sz and cz passed on
    logic signed [TW-1:0] r_czcy, r_szcx, r_czsy, r_szcy, r_czcx;
    logic signed [TW-1:0] r_szsy, r_cxsy, r_cxcy, r_sxsy, r_sxcy;
    logic signed [TW-1:0] r_sx, r_sz, r_cz;
    logic [NUM_AXES-1:0][SCALE_W-1:0]  r_scale3;
    logic [NUM_AXES-1:0][SCALE_W-1:0]  r_scale4;
    logic [NUM_ENTRIES-1:0][CW-1:0]    r_coef4;
    logic [NUM_ENTRIES-1:0][CW-1:0]    n_coef4;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign o_ready = w_en3;

    // Stage 4: second products and the row sums
    always_comb begin
        logic signed [TW-1:0] v_szsxsy;
        logic signed [TW-1:0] v_szsxcy;
        logic signed [TW-1:0] v_czsxsy;
        logic signed [TW-1:0] v_czsxcy;
        v_szsxsy   = tmul(r_sz, r_sxsy);
        v_szsxcy   = tmul(r_sz, r_sxcy);
        v_czsxsy   = tmul(r_cz, r_sxsy);
        v_czsxcy   = tmul(r_cz, r_sxcy);
        n_coef4[0] = CW'(r_czcy) - CW'(v_szsxsy);
        n_coef4[1] = -CW'(r_szcx);
        n_coef4[2] = CW'(r_czsy) + CW'(v_szsxcy);
        n_coef4[3] = CW'(r_szcy) + CW'(v_czsxsy);
        n_coef4[4] = CW'(r_czcx);
        n_coef4[5] = CW'(r_szsy) - CW'(v_czsxcy);
        n_coef4[6] = -CW'(r_cxsy);
        n_coef4[7] = CW'(r_sx);
        n_coef4[8] = CW'(r_cxcy);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en3) begin
                r_v3 <= i_valid;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_en3 && i_valid) begin
            r_czcy   <= tmul($signed(i_cos[AZ]), $signed(i_cos[AY]));
            r_szcx   <= tmul($signed(i_sin[AZ]), $signed(i_cos[AX]));
            r_czsy   <= tmul($signed(i_cos[AZ]), $signed(i_sin[AY]));
            r_szcy   <= tmul($signed(i_sin[AZ]), $signed(i_cos[AY]));
            r_czcx   <= tmul($signed(i_cos[AZ]), $signed(i_cos[AX]));
            r_szsy   <= tmul($signed(i_sin[AZ]), $signed(i_sin[AY]));
            r_cxsy   <= tmul($signed(i_cos[AX]), $signed(i_sin[AY]));
            r_cxcy   <= tmul($signed(i_cos[AX]), $signed(i_cos[AY]));
            r_sxsy   <= tmul($signed(i_sin[AX]), $signed(i_sin[AY]));
            r_sxcy   <= tmul($signed(i_sin[AX]), $signed(i_cos[AY]));
            r_sx     <= $signed(i_sin[AX]);
            r_sz     <= $signed(i_sin[AZ]);
            r_cz     <= $signed(i_cos[AZ]);
            r_scale3 <= i_scale;
        end
        if (w_en4 && r_v3) begin
            r_coef4  <= n_coef4;
            r_scale4 <= r_scale3;
        end
    end

    assign o_valid = r_v4;
    assign o_coef  = r_coef4;
    assign o_scale = r_scale4;

endmodule

### rtl/seru_scale.sv
// Row scaling, rounding and saturation into the output register.
// Depends on seru_pkg for result width and limits.
module seru_scale #(
    parameter int TRIG_FRAC_BITS = seru_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_valid,
    output logic                                                  o_ready,
    input  logic [seru_pkg::NUM_ENTRIES-1:0][TRIG_FRAC_BITS+2:0]  i_coef,
    input  logic [seru_pkg::NUM_AXES-1:0][seru_pkg::SCALE_W-1:0]  i_scale,
    output logic                                                  o_valid,
    input  logic                                                  i_ready,
    output logic [seru_pkg::NUM_ENTRIES-1:0][seru_pkg::RES_W-1:0] o_entry
);
    import seru_pkg::*;

    localparam int CW = TRIG_FRAC_BITS + 3;
    localparam int MW = CW + SCALE_W;
    localparam int QW = MW + 1 - TRIG_FRAC_BITS;
    localparam logic [QW-1:0] POS_LIM = QW'((1 << (RES_W - 1)) - 1);
    localparam logic [QW-1:0] NEG_LIM = QW'(1 << (RES_W - 1));

    // coef * scale, rounded half away from zero, saturated to RES_W
    function automatic logic [RES_W-1:0] scale_sat(input logic signed [CW-1:0] c,
                                                   input logic signed [SCALE_W-1:0] s);
        logic signed [MW-1:0] p;
        logic [MW-1:0]        mag;
        logic [MW:0]          rnd;
        logic [QW-1:0]        q;
        p   = c * s;
        mag = p[MW-1] ? -p : p;
        rnd = ({1'b0, mag} + ((MW + 1)'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
        q   = rnd[QW-1:0];
        if (p[MW-1]) begin
            return (q > NEG_LIM) ? NEG_LIM[RES_W-1:0] : RES_W'(-q);
        end
        return (q > POS_LIM) ? POS_LIM[RES_W-1:0] : q[RES_W-1:0];
    endfunction

    logic                               w_en5;
    logic                               r_v5;
    logic [NUM_ENTRIES-1:0][RES_W-1:0]  r_entry5;
    logic [NUM_ENTRIES-1:0][RES_W-1:0]  n_entry5;

    assign w_en5   = !r_v5 || i_ready;
    assign o_ready = w_en5;

    // One multiplier per entry; the row selects the scale
    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_ent
        localparam int ROW = g / NUM_AXES;
        assign n_entry5[g] = scale_sat($signed(i_coef[g]), $signed(i_scale[ROW]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en5 && i_valid) begin
            r_entry5 <= n_entry5;
        end
    end

    assign o_valid = r_v5;
    assign o_entry = r_entry5;

endmodule

### rtl/scaled_euler_rotation_matrix_unit.sv
// Scaled Euler rotation matrix unit: top level, stream ports and assertions.
// Depends on seru_pkg, seru_angle, seru_coef, seru_scale and the assert header.
//
// Usage: one request on the slave stream carries three whole-degree angles
// and three signed Q8.8 row scales; one result on the master stream carries
// the nine entries of R = Rz * Rx * Ry, row r multiplied by its scale, each
// rounded and saturated to signed Q8.8. Angles of 360 and above wrap.
// Throughput: one request per cycle, sustained while the receiver takes results.
// Pipeline stages from input accept to output valid: angle wrap, table
// lookup, first trig products, second products with row sums, and the
// scale multiply into the output register.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// keep whatever they hold. When the receiver stalls, results stay in place,
// empty stages still fill, and the input is refused only once every stage
// holds an item.
`include "scaled_euler_rotation_matrix_unit_assert.svh"

module scaled_euler_rotation_matrix_unit #(
    parameter int TRIG_FRAC_BITS = seru_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata: angle_x[8:0], angle_y[17:9], angle_z[26:18], scale_x[42:27],
    //        scale_y[58:43], scale_z[74:59], zero fill [79:75]
    input  logic [79:0]  i_s_axis_tdata,
    // master stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: entry_00[15:0], entry_01, entry_02, entry_10, entry_11,
    //        entry_12, entry_20, entry_21, entry_22[143:128]
    output logic [143:0] o_m_axis_tdata
);
    import seru_pkg::*;

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int CW = TRIG_FRAC_BITS + 3;

    logic [NUM_AXES-1:0][ANGLE_W-1:0]   w_angle;
    logic [NUM_AXES-1:0][SCALE_W-1:0]   w_scale;
    logic                               w_ang_valid;
    logic                               w_ang_ready;
    logic [NUM_AXES-1:0][TW-1:0]        w_sin;
    logic [NUM_AXES-1:0][TW-1:0]        w_cos;
    logic [NUM_AXES-1:0][SCALE_W-1:0]   w_ang_scale;
    logic                               w_coef_valid;
    logic                               w_coef_ready;
    logic [NUM_ENTRIES-1:0][CW-1:0]     w_coef;
    logic [NUM_AXES-1:0][SCALE_W-1:0]   w_coef_scale;
    logic [NUM_ENTRIES-1:0][RES_W-1:0]  w_entry;

    // Unpack request fields
    assign w_angle[AX] = i_s_axis_tdata[8:0];
    assign w_angle[AY] = i_s_axis_tdata[17:9];
    assign w_angle[AZ] = i_s_axis_tdata[26:18];
    assign w_scale[AX] = i_s_axis_tdata[42:27];
    assign w_scale[AY] = i_s_axis_tdata[58:43];
    assign w_scale[AZ] = i_s_axis_tdata[74:59];

    seru_angle #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_angle (w_angle),
        .i_scale (w_scale),
        .o_valid (w_ang_valid),
        .i_ready (w_ang_ready),
        .o_sin   (w_sin),
        .o_cos   (w_cos),
        .o_scale (w_ang_scale)
    );

    seru_coef #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ang_valid),
        .o_ready (w_ang_ready),
        .i_sin   (w_sin),
        .i_cos   (w_cos),
        .i_scale (w_ang_scale),
        .o_valid (w_coef_valid),
        .i_ready (w_coef_ready),
        .o_coef  (w_coef),
        .o_scale (w_coef_scale)
    );

    seru_scale #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_coef_valid),
        .o_ready (w_coef_ready),
        .i_coef  (w_coef),
        .i_scale (w_coef_scale),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_entry (w_entry)
    );

    // Pack result, entry_00 in the lowest bits
    assign o_m_axis_tdata = w_entry;

    // Input refused only when every stage boundary holds an item
    `SERU_ASSERT_IMPL(a_full_when_refused, i_clk, i_rst_n, !o_s_axis_tready,
        w_ang_valid && w_coef_valid && o_m_axis_tvalid, "input refused with a bubble inside")
    // An item handed to the scale stage shows at the output next cycle
    `SERU_ASSERT_NEXT(a_scale_lands, i_clk, i_rst_n, w_coef_valid && w_coef_ready,
        o_m_axis_tvalid, "item lost entering the output register")
    // A stalled result blocks the coefficient hand-off
    `SERU_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        !w_coef_ready, "output register overwritten while stalled")

endmodule

### verif/scaled_euler_rotation_matrix_unit_test.sv
// Self-checking bench for scaled_euler_rotation_matrix_unit: directed and random angle/scale
// requests, with the expected matrix built by a scoreboard that holds its own trig table.
// Depends on seru_pkg and the unit under test; no files or arguments.
module scaled_euler_rotation_matrix_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import seru_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 1830;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 40;

    // Builds the expected matrix for each accepted request and checks results in order
    class rotation_scoreboard;
        longint       sin_tab [QUARTER];
        longint       cos_tab [QUARTER];
        logic [143:0] expected_matrices [$];
        int           fail_count;
        int           report_count;

        function new();
            longint unsigned step;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned ts;
            longint unsigned tc;
            longint          ss;
            longint          cs;
            step = PI_Q62 / 64'(ANGLE_STEPS / 2);
            fail_count   = 0;
            report_count = 0;
            // first-quadrant table from a fixed-point Taylor series in Q30
            for (int r = 0; r < QUARTER; r++) begin
                x  = (64'(r) * step + (64'd1 << 31)) >> 32;
                x2 = (x * x) >> WORK_BITS;
                ts = x;
                tc = 64'd1 << WORK_BITS;
                ss = longint'(ts);
                cs = longint'(tc);
                for (int k = 1; k <= SERIES_TERMS; k++) begin
                    ts = ((ts * x2) >> WORK_BITS) / 64'((2 * k) * (2 * k + 1));
                    tc = ((tc * x2) >> WORK_BITS) / 64'((2 * k - 1) * (2 * k));
                    if (k % 2 == 1) begin
                        ss = ss - longint'(ts);
                        cs = cs - longint'(tc);
                    end else begin
                        ss = ss + longint'(ts);
                        cs = cs + longint'(tc);
                    end
                end
                sin_tab[r] = round_half_away(ss, WORK_BITS - TRIG_FRAC_BITS_DEF);
                cos_tab[r] = round_half_away(cs, WORK_BITS - TRIG_FRAC_BITS_DEF);
            end
        endfunction

        // v / 2^sh, ties away from zero
        function longint round_half_away(longint v, int sh);
            longint unsigned mag;
            if (sh == 0) begin
                return v;
            end
            mag = (v < 0) ? 64'(-v) : 64'(v);
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint trig_product(longint a, longint b);
            return round_half_away(a * b, TRIG_FRAC_BITS_DEF);
        endfunction

        // angles wrap modulo a full turn, other quadrants by symmetry
        function void trig_lookup(input logic [8:0] angle, output longint s, output longint c);
            int         a;
            int         base;
            logic [1:0] quad;
            a    = int'(angle) % ANGLE_STEPS;
            quad = 2'(a / QUARTER);
            base = a % QUARTER;
            case (quad)
                QUAD_0: begin
                    s = sin_tab[base];
                    c = cos_tab[base];
                end
                QUAD_1: begin
                    s = cos_tab[base];
                    c = -sin_tab[base];
                end
                QUAD_2: begin
                    s = -sin_tab[base];
                    c = -cos_tab[base];
                end
                default: begin
                    s = -cos_tab[base];
                    c = sin_tab[base];
                end
            endcase
        endfunction

        // R = Rz * Rx * Ry, each row times its scale, rounded and saturated
        function logic [143:0] predict_matrix(logic [79:0] req);
            longint       s [NUM_AXES];
            longint       c [NUM_AXES];
            longint       scl [NUM_AXES];
            longint       coef [NUM_ENTRIES];
            longint       sxsy;
            longint       sxcy;
            longint       v;
            logic [143:0] m;
            for (int a = 0; a < NUM_AXES; a++) begin
                trig_lookup(req[9 * a +: 9], s[a], c[a]);
                scl[a] = longint'($signed(req[27 + 16 * a +: 16]));
            end
            sxsy = trig_product(s[AX], s[AY]);
            sxcy = trig_product(s[AX], c[AY]);
            coef[0] = trig_product(c[AZ], c[AY]) - trig_product(s[AZ], sxsy);
            coef[1] = -trig_product(s[AZ], c[AX]);
            coef[2] = trig_product(c[AZ], s[AY]) + trig_product(s[AZ], sxcy);
            coef[3] = trig_product(s[AZ], c[AY]) + trig_product(c[AZ], sxsy);
            coef[4] = trig_product(c[AZ], c[AX]);
            coef[5] = trig_product(s[AZ], s[AY]) - trig_product(c[AZ], sxcy);
            coef[6] = -trig_product(c[AX], s[AY]);
            coef[7] = s[AX];
            coef[8] = trig_product(c[AX], c[AY]);
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                v = round_half_away(coef[k] * scl[k / 3], TRIG_FRAC_BITS_DEF);
                if (v > 32767) begin
                    v = 32767;
                end
                if (v < -32768) begin
                    v = -32768;
                end
                m[16 * k +: 16] = v[15:0];
            end
            return m;
        endfunction

        function void note_request(logic [79:0] req);
            expected_matrices.push_back(predict_matrix(req));
        endfunction

        function void check_result(logic [143:0] got);
            logic [143:0] want;
            if (expected_matrices.size() == 0) begin
                fail_count++;
                $display("%0t: result with no request pending, got %h", $time, got);
                return;
            end
            want = expected_matrices.pop_front();
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                if (got[16 * k +: 16] !== want[16 * k +: 16]) begin
                    fail_count++;
                    if (report_count < REPORT_MAX) begin
                        report_count++;
                        $display("%0t: entry_%0d%0d mismatch, expected %0d, actual %0d",
                                 $time, k / 3, k % 3, $signed(want[16 * k +: 16]),
                                 $signed(got[16 * k +: 16]));
                    end
                end
            end
        endfunction

        function int pending();
            return expected_matrices.size();
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [79:0]  i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [143:0] o_m_axis_tdata;

    rotation_scoreboard scoreboard = new();

    // idling control shared by sender, receiver and main sequence
    bit tx_calm;
    bit rx_calm;
    int hold_asked;

    scaled_euler_rotation_matrix_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // handshake monitor: feeds the scoreboard on both sides
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            scoreboard.note_request(i_s_axis_tdata);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            scoreboard.check_result(o_m_axis_tdata);
        end
    end

    // receiver: random back-pressure, calm stretches, and long hold-offs on demand
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_calm) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= 30);
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic [79:0] pack_request(int ax, int ay, int az,
                                                 logic [15:0] sx, logic [15:0] sy,
                                                 logic [15:0] sz);
        return {5'b0, sz, sy, sx, 9'(az), 9'(ay), 9'(ax)};
    endfunction

    function automatic int random_angle();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return 0;
        end
        if (pick < 25) begin
            return int'($urandom_range(511, 360));
        end
        return int'($urandom_range(359));
    endfunction

    // mix of full-range, small, extreme and unit scales
    function automatic logic [15:0] random_scale();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            return 16'($urandom);
        end
        if (pick < 80) begin
            return 16'($urandom_range(2048)) - 16'd1024;
        end
        if (pick < 90) begin
            return pick[0] ? 16'h7FFF : 16'h8000;
        end
        return pick[0] ? 16'h0100 : 16'hFF00;
    endfunction

    // offer one request, with an optional idle gap first, until accepted
    task automatic send_request(input logic [79:0] req);
        if (!tx_calm && $urandom_range(99) < 30) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= req;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    initial begin
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        hold_asked = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all angles zero: scales land on the diagonal
        send_request(pack_request(0, 0, 0, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000));
        // each combination of zero and nonzero angles
        send_request(pack_request(30, 0, 0, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(0, 45, 0, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(0, 0, 60, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(30, 45, 0, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(30, 0, 60, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(0, 45, 60, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(30, 45, 60, 16'h0100, 16'h0100, 16'h0100));
        // quadrant boundaries and the last degree
        send_request(pack_request(90, 180, 270, 16'h0100, 16'hFF00, 16'h0200));
        send_request(pack_request(270, 90, 180, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(359, 359, 359, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(1, 89, 91, 16'h0100, 16'h0100, 16'h0100));
        // angles past a full turn wrap around
        send_request(pack_request(360, 360, 360, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(511, 450, 400, 16'h0100, 16'h0100, 16'h0100));
        send_request(pack_request(511, 511, 511, 16'hFFFF, 16'h8000, 16'h7FFF));
        // saturation at both rails
        send_request(pack_request(45, 45, 45, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_request(pack_request(135, 225, 315, 16'h8000, 16'h7FFF, 16'h8000));
        send_request(pack_request(0, 0, 0, 16'h8000, 16'h8000, 16'h8000));
        // smallest nonzero scales, rounding of halves
        send_request(pack_request(60, 30, 120, 16'h0001, 16'hFFFF, 16'h0001));
        send_request(pack_request(300, 210, 150, 16'h0003, 16'hFFFD, 16'h0002));

        // random requests; calm stretches with a receiver hold-off so the pipe fills
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 0 || i == 1000) begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
                hold_asked++;
            end else if (i == 150 || i == 1100) begin
                tx_calm = 1'b0;
                rx_calm = 1'b0;
            end
            send_request(pack_request(random_angle(), random_angle(), random_angle(),
                                      random_scale(), random_scale(), random_scale()));
        end
        i_s_axis_tvalid <= 1'b0;

        // drain, then allow for late extra results
        while (scoreboard.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (scoreboard.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/seru_pkg.sv
rtl/seru_angle.sv
rtl/seru_coef.sv
rtl/seru_scale.sv
rtl/scaled_euler_rotation_matrix_unit.sv
verif/scaled_euler_rotation_matrix_unit_test.sv
